[rtl/ecm_pkg.sv]
`timescale 1ns / 1ps

package ecm_pkg;

  // Widest map index that the queue entries can carry.
  localparam int unsigned MAP_IDX_MAX = 20;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_COVERAGE_ENABLE = 3'd0;

  typedef enum logic [1:0] {
    FUNC_EVENT   = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_NEW_RUN = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                    kind;
    logic [MAP_IDX_MAX-1:0] idx;
  } op_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

[rtl/ecm_if.sv]
`timescale 1ns / 1ps

interface ecm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] block_address;
  logic [15:0] read_index;

  modport source (output valid, func, block_address, read_index, input ready);
  modport sink (input valid, func, block_address, read_index, output ready);
endinterface

interface ecm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] map_index;
  logic [7:0]  hit_count;
  logic        counted;

  modport source (output valid, map_index, hit_count, counted, input ready);
  modport sink (input valid, map_index, hit_count, counted, output ready);
endinterface

[rtl/ecm_ram.sv]
`timescale 1ns / 1ps

module ecm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ecm_queue.sv]
`timescale 1ns / 1ps

module ecm_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  ecm_pkg::op_t push_data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  logic         pop_i,
  output ecm_pkg::op_t pop_data_o
);
  import ecm_pkg::*;

  op_t                    entry_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push, do_pop;

  assign ready_o    = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/ecm_front.sv]
`timescale 1ns / 1ps

module ecm_front #(
  parameter int unsigned MAP_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ecm_in_if.sink               in_if,
  input  logic                 enable_i,
  input  ecm_pkg::back_status_t status_i,
  input  logic                 q_ready_i,
  output logic                 q_push_o,
  output ecm_pkg::op_t         q_data_o
);
  import ecm_pkg::*;

  logic [MAP_BITS-2:0] prev_q, prev_d;
  logic [31:0]         hash_full;
  logic [MAP_BITS-1:0] loc;
  logic [MAP_BITS-1:0] event_idx;
  logic [MAP_BITS-1:0] read_idx;
  logic [MAP_BITS-1:0] op_idx;
  op_e                 op_kind;
  logic                accept;

  assign in_if.ready = q_ready_i && !status_i.clearing;
  assign accept      = in_if.valid && in_if.ready;

  assign hash_full = (in_if.block_address >> 4) ^ (in_if.block_address << 8);
  assign loc       = hash_full[MAP_BITS-1:0];
  assign event_idx = loc ^ {1'b0, prev_q};
  assign read_idx  = MAP_BITS'(32'(in_if.read_index));

  always_comb begin
    op_kind = OP_NONE;
    op_idx  = '0;
    prev_d  = prev_q;
    case (func_e'(in_if.func))
      FUNC_EVENT: begin
        if (enable_i) begin
          op_kind = OP_COUNT;
          op_idx  = event_idx;
          prev_d  = loc[MAP_BITS-1:1];
        end
      end
      FUNC_READ: begin
        op_kind = OP_READ;
        op_idx  = read_idx;
      end
      FUNC_NEW_RUN: begin
        prev_d = '0;
      end
      default: begin
        op_kind = OP_NONE;
      end
    endcase
  end

  assign q_push_o      = accept;
  assign q_data_o.kind = op_kind;
  assign q_data_o.idx  = MAP_IDX_MAX'(op_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (accept) begin
      prev_q <= prev_d;
    end
  end

endmodule

[rtl/ecm_back.sv]
`timescale 1ns / 1ps

module ecm_back #(
  parameter int unsigned MAP_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  ecm_pkg::op_t          q_data_i,
  output logic                  q_pop_o,
  output ecm_pkg::back_status_t status_o,
  ecm_out_if.source             out_if
);
  import ecm_pkg::*;

  logic                clearing_q;
  logic [MAP_BITS-1:0] clr_addr_q;

  logic                r_valid_q;
  op_e                 r_kind_q;
  logic [MAP_BITS-1:0] r_idx_q;
  logic                r_adv;

  logic                lw_valid_q;
  logic [MAP_BITS-1:0] lw_addr_q;
  logic [7:0]          lw_data_q;

  logic                ram_we;
  logic [MAP_BITS-1:0] ram_waddr;
  logic [7:0]          ram_wdata;
  logic [7:0]          ram_rdata;

  logic [7:0]          cur_count;
  logic [7:0]          new_count;
  logic [31:0]         idx_wide;

  logic                out_valid_q;
  logic [15:0]         out_index_q;
  logic [7:0]          out_count_q;
  logic                out_counted_q;

  assign status_o.clearing = clearing_q;

  assign r_adv   = r_valid_q && (!out_valid_q || out_if.ready);
  assign q_pop_o = q_valid_i && !clearing_q && (!r_valid_q || r_adv);

  // The latest write to the entry wins over the registered read data.
  assign cur_count = (lw_valid_q && (lw_addr_q == r_idx_q)) ? lw_data_q : ram_rdata;
  assign new_count = cur_count + 8'd1;
  assign idx_wide  = 32'(r_idx_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = r_idx_q;
    ram_wdata = new_count;
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (r_adv && (r_kind_q == OP_COUNT)) begin
      ram_we = 1'b1;
    end
  end

  ecm_ram #(
    .Width(8),
    .Depth(2 ** MAP_BITS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (q_pop_o),
    .raddr_i(q_data_i.idx[MAP_BITS-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      r_valid_q   <= 1'b0;
      lw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
      if (q_pop_o) begin
        r_valid_q <= 1'b1;
      end else if (r_adv) begin
        r_valid_q <= 1'b0;
      end
      if (ram_we && !clearing_q) begin
        lw_valid_q <= 1'b1;
      end
      if (r_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      r_kind_q <= q_data_i.kind;
      r_idx_q  <= q_data_i.idx[MAP_BITS-1:0];
    end
    if (ram_we && !clearing_q) begin
      lw_addr_q <= ram_waddr;
      lw_data_q <= ram_wdata;
    end
    if (r_adv) begin
      out_index_q   <= (r_kind_q == OP_NONE) ? 16'd0 : idx_wide[15:0];
      out_counted_q <= (r_kind_q == OP_COUNT);
      case (r_kind_q)
        OP_COUNT: out_count_q <= new_count;
        OP_READ:  out_count_q <= cur_count;
        default:  out_count_q <= 8'd0;
      endcase
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.map_index = out_index_q;
  assign out_if.hit_count = out_count_q;
  assign out_if.counted   = out_counted_q;

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !q_pop_o)
    else $error("Request taken from the queue during the map clear.");

  a_clear_sweeps_whole_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> ($past(clr_addr_q) == '1))
    else $error("Map clear ended before the last entry.");

  a_none_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_adv && (r_kind_q == OP_NONE)) |=>
      (out_if.valid && (out_if.map_index == 16'd0) && (out_if.hit_count == 8'd0)
       && !out_if.counted))
    else $error("A request without map access gave a non-zero result.");

  a_result_after_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_adv |=> out_valid_q)
    else $error("Result register did not load.");

endmodule

[rtl/edge_coverage_map_update_top.sv]
`timescale 1ns / 1ps
// Edge coverage map: counts control-flow edges into a map of 8-bit counters.
// Requests arrive on in_if (valid/ready): func 0 is a block event, which hashes
// block_address, bumps the counter at hash XOR previous location shifted right
// by one and reports it; func 1 reads the counter at read_index; func 2 starts
// a new run. Every request gives exactly one result on out_if (valid/ready).
// The APB port holds coverage_enable at address 0; block events are ignored
// and give an all-zero result while it is 0.
// From acceptance a request passes through the queue and then the map stage,
// whose registered map read ends as the result register loads.
// Throughput is one request per cycle while out_if.ready stays high, set by
// the single map read and write port with forwarding of the latest write.
// After reset the map's 2**MAP_BITS entries are cleared one entry per cycle,
// and in_if.ready stays low until then; configuration writes are taken
// throughout. When the receiver stalls, the result register, the map stage and
// the two-entry queue fill in turn before in_if.ready falls.

module edge_coverage_map_update_top #(
  parameter int unsigned MAP_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ecm_in_if.sink                             in_if,
  ecm_out_if.source                          out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ecm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ecm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ecm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import ecm_pkg::*;

  logic         enable_q;
  logic         q_push, q_ready, q_valid, q_pop;
  op_t          q_push_data, q_pop_data;
  back_status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_COVERAGE_ENABLE) ? APB_DATA_W'(enable_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == REG_COVERAGE_ENABLE)) begin
      enable_q <= pwdata[0];
    end
  end

  ecm_front #(
    .MAP_BITS(MAP_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .enable_i (enable_q),
    .status_i (status),
    .q_ready_i(q_ready),
    .q_push_o (q_push),
    .q_data_o (q_push_data)
  );

  ecm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_push_data),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .pop_data_o (q_pop_data)
  );

  ecm_back #(
    .MAP_BITS(MAP_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_data_i (q_pop_data),
    .q_pop_o  (q_pop),
    .status_o (status),
    .out_if   (out_if)
  );

endmodule

[tb/edge_coverage_map_update_checker.sv]
`timescale 1ns / 1ps

module edge_coverage_map_update_checker #(
  parameter int unsigned MAP_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ecm_in_if                              req_mon,
  ecm_out_if                             rsp_mon,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ecm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ecm_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [ecm_pkg::APB_DATA_W-1:0] prdata,
  input  logic                           pready,
  output int unsigned                    fail_count,
  output int unsigned                    pending_count,
  output int unsigned                    checked_count,
  output int unsigned                    wrap_count,
  output logic [15:0]                    last_hit_index
);
  import ecm_pkg::*;

  localparam int unsigned MAP_SIZE = 1 << MAP_BITS;

  typedef struct packed {
    logic [15:0] map_index;
    logic [7:0]  hit_count;
    logic        counted;
  } hit_report_t;

  logic [7:0]          hit_map [MAP_SIZE];
  logic [MAP_BITS-2:0] prev_loc;
  logic                cov_en;
  hit_report_t         report_q [$];
  int unsigned         n_fail;
  int unsigned         n_checked;
  int unsigned         n_wrap;

  function automatic hit_report_t bump_or_read(logic [1:0] func, logic [31:0] addr,
                                               logic [15:0] ridx);
    hit_report_t         rep;
    logic [31:0]         mixed;
    logic [MAP_BITS-1:0] loc;
    logic [MAP_BITS-1:0] slot;
    rep = '0;
    case (func_e'(func))
      FUNC_EVENT: begin
        if (cov_en) begin
          mixed = (addr >> 4) ^ (addr << 8);
          loc = mixed[MAP_BITS-1:0];
          slot = loc ^ MAP_BITS'(prev_loc);
          hit_map[slot] = hit_map[slot] + 8'd1;
          rep.map_index = 16'(slot);
          rep.hit_count = hit_map[slot];
          rep.counted = 1'b1;
          prev_loc = loc[MAP_BITS-1:1];
        end
      end
      FUNC_READ: begin
        slot = MAP_BITS'(ridx);
        rep.map_index = 16'(slot);
        rep.hit_count = hit_map[slot];
      end
      FUNC_NEW_RUN: begin
        prev_loc = '0;
      end
      default: begin
      end
    endcase
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hit_report_t got;
    hit_report_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAP_SIZE; i++) hit_map[i] = '0;
      prev_loc = '0;
      cov_en = 1'b0;
      report_q.delete();
      n_fail = 0;
      n_checked = 0;
      n_wrap = 0;
      last_hit_index <= '0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = '{rsp_mon.map_index, rsp_mon.hit_count, rsp_mon.counted};
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got index %h count %h counted %b",
                   $time, got.map_index, got.hit_count, got.counted);
          n_fail++;
        end else begin
          want = report_q.pop_front();
          n_checked++;
          if (got !== want) begin
            $display("%0t: result mismatch, expected index %h count %h counted %b, got %h %h %b",
                     $time, want.map_index, want.hit_count, want.counted,
                     got.map_index, got.hit_count, got.counted);
            n_fail++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        want = bump_or_read(req_mon.func, req_mon.block_address, req_mon.read_index);
        if (want.counted) begin
          last_hit_index <= want.map_index;
          if (want.hit_count == 8'd0) n_wrap++;
        end
        report_q.push_back(want);
      end
      if (psel && penable && pready && !pwrite && paddr == REG_COVERAGE_ENABLE) begin
        if (prdata !== APB_DATA_W'(cov_en)) begin
          $display("%0t: register read mismatch, expected %h, got %h",
                   $time, APB_DATA_W'(cov_en), prdata);
          n_fail++;
        end
      end
      if (psel && penable && pready && pwrite && paddr == REG_COVERAGE_ENABLE) begin
        cov_en = pwdata[0];
      end
    end
    fail_count <= n_fail;
    checked_count <= n_checked;
    wrap_count <= n_wrap;
    pending_count <= report_q.size();
  end

endmodule

[tb/edge_coverage_map_update_top_tb.sv]
`timescale 1ns / 1ps

module edge_coverage_map_update_top_tb;
  import ecm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned wrap_count;
  logic [15:0] last_hit_index;

  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  logic [31:0] addr_pool [8];

  ecm_in_if  req_bus ();
  ecm_out_if rsp_bus ();

  edge_coverage_map_update_top #(
    .MAP_BITS(16)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (req_bus),
    .out_if  (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  edge_coverage_map_update_checker #(
    .MAP_BITS(16)
  ) map_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_bus),
    .rsp_mon        (rsp_bus),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count),
    .wrap_count     (wrap_count),
    .last_hit_index (last_hit_index)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rsp_bus.ready <= rst_ni && ($urandom_range(0, 99) >= dst_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("FAIL edge_coverage_map_update_top");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] func, input logic [31:0] addr,
                              input logic [15:0] ridx);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.func <= func;
    req_bus.block_address <= addr;
    req_bus.read_index <= ridx;
    do @(posedge clk_i); while (!req_bus.ready);
    sent_count++;
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the enable register and reads it back in a second transfer.
  task automatic write_enable(input logic value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_COVERAGE_ENABLE;
    pwdata <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly events, many from a small address pool so that counters build up along
  // repeated paths, mixed with reads of freshly bumped entries and noise.
  task automatic run_segment(input logic enable, input int unsigned count);
    int unsigned roll;
    logic [31:0] noise_a;
    logic [15:0] noise_i;
    wait_drained();
    write_enable(enable);
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      noise_a = $urandom();
      noise_i = 16'($urandom());
      if (roll < 45) send_request(FUNC_EVENT, addr_pool[$urandom_range(0, 7)], noise_i);
      else if (roll < 60) send_request(FUNC_EVENT, noise_a, noise_i);
      else if (roll < 72) send_request(FUNC_READ, noise_a, last_hit_index);
      else if (roll < 84) send_request(FUNC_READ, noise_a, noise_i);
      else if (roll < 94) send_request(FUNC_NEW_RUN, noise_a, noise_i);
      else send_request(FUNC_UNUSED, noise_a, noise_i);
    end
  endtask

  initial begin
    logic [31:0] burst_addr;
    rst_ni <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.func <= FUNC_EVENT;
    req_bus.block_address <= '0;
    req_bus.read_index <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    src_idle_pct = 9;
    dst_idle_pct = 58;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) addr_pool[i] = $urandom();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Coverage still off: events must leave the map alone.
    write_enable(1'b0);
    send_request(FUNC_EVENT, 32'hFFFF_FFFF, 16'h0000);
    send_request(FUNC_EVENT, 32'h1234_5678, 16'hFFFF);
    send_request(FUNC_READ, 32'h0000_0000, 16'h0000);
    send_request(FUNC_READ, 32'hFFFF_FFFF, 16'hFFFF);
    wait_drained();
    write_enable(1'b1);
    send_request(FUNC_EVENT, 32'h0000_0000, 16'h0000);
    send_request(FUNC_EVENT, 32'hFFFF_FFFF, 16'h0000);
    send_request(FUNC_EVENT, 32'hFFFF_FFFF, 16'h0000);
    send_request(FUNC_EVENT, 32'h1234_5678, 16'h0000);
    send_request(FUNC_NEW_RUN, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(FUNC_EVENT, 32'h1234_5678, 16'h0000);
    send_request(FUNC_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(FUNC_READ, 32'h0000_0000, last_hit_index);
    send_request(FUNC_READ, 32'h0000_0000, 16'h0000);
    send_request(FUNC_READ, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(FUNC_EVENT, 32'h0000_000F, 16'h0000);
    send_request(FUNC_EVENT, 32'h0000_00F0, 16'h0000);
    send_request(FUNC_EVENT, 32'h00FF_0000, 16'h0000);
    send_request(FUNC_EVENT, 32'hFF00_0000, 16'h0000);
    send_request(FUNC_NEW_RUN, 32'h0000_0000, 16'h0000);
    send_request(FUNC_NEW_RUN, 32'h0000_0000, 16'h0000);
    send_request(FUNC_UNUSED, 32'h0000_0000, 16'h0000);
    send_request(FUNC_READ, 32'h0000_0000, last_hit_index);

    run_segment(1'b1, 380);
    src_idle_pct = 58;
    dst_idle_pct = 9;
    run_segment(1'b0, 50);
    run_segment(1'b1, 330);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_segment(1'b1, 120);

    // A long run of one address hits a single entry often enough to wrap it.
    burst_addr = $urandom();
    for (int n = 0; n < 260; n++) send_request(FUNC_EVENT, burst_addr, 16'($urandom()));
    send_request(FUNC_READ, 32'h0000_0000, last_hit_index);
    wait_drained();

    $display("Sent %0d requests and checked %0d results, with coverage on and off.",
             sent_count, checked_count);
    $display("Counter wraps seen: %0d; idling on both sides, either side and neither.",
             wrap_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS edge_coverage_map_update_top");
    end else begin
      $display("FAIL edge_coverage_map_update_top");
    end
    $finish;
  end

endmodule
